>>> hdl/slm_pkg.sv
package slm_pkg;

  localparam int WORD_BITS      = 32;
  localparam int SAMPLE_BITS    = 24;
  localparam int SQUARE_BITS    = 2 * SAMPLE_BITS;
  localparam int SUM_BITS       = 64;
  localparam int COUNT_BITS     = 16;
  localparam int WINDOW_N_BITS  = COUNT_BITS + 1;
  localparam int POS_BITS       = 6;
  localparam int LOG_FRAC_BITS  = 6;
  localparam int FRAC_ENTRIES   = 1 << LOG_FRAC_BITS;
  localparam int LOG_Q_BITS     = 16;
  localparam int LOG_BITS       = POS_BITS + LOG_Q_BITS;
  localparam int COEF_BITS      = 21;
  localparam int PROD_BITS      = LOG_BITS + COEF_BITS;
  localparam int TERM_BITS      = 12;
  localparam int LEVEL_BITS     = 14;
  localparam int MAG_BITS       = 13;
  localparam int RECIP_BITS     = 13;
  localparam int RECIP_SHIFT    = 16;
  localparam int QUOT_BITS      = 10;
  localparam int CAL_BITS       = 12;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 1;
  localparam int WHOLE_BITS     = 10;
  localparam int TENTH_BITS     = 4;

  localparam logic [COEF_BITS-1:0]   LEVEL_COEF      = 21'd1972830;
  localparam logic [RECIP_BITS-1:0]  RECIP_TEN       = 13'd6554;
  localparam logic [COUNT_BITS-1:0]  WINDOW_RESET    = 16'd20000;
  localparam logic [CAL_BITS-1:0]    CAL_RESET       = 12'hF6B;
  localparam logic [POS_BITS-1:0]    POS_TOP         = 6'd63;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LENGTH      = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CALIBRATION_OFFSET = 1'd1;

  typedef logic [LOG_Q_BITS-1:0] frac_table_t [FRAC_ENTRIES];

  function automatic frac_table_t build_frac_table();
    frac_table_t      tbl;
    logic [63:0]      m;
    logic [LOG_Q_BITS-1:0] r;
    for (int k = 0; k < FRAC_ENTRIES; k++) begin
      m = (64'(FRAC_ENTRIES) + 64'(k)) << (30 - LOG_FRAC_BITS);
      r = '0;
      for (int i = 0; i < LOG_Q_BITS; i++) begin
        m = (m * m) >> 30;
        r = {r[LOG_Q_BITS-2:0], 1'b0};
        if (m >= 64'h8000_0000) begin
          r[0] = 1'b1;
          m = m >> 1;
        end
      end
      tbl[k] = r;
    end
    return tbl;
  endfunction

  localparam frac_table_t LOG_FRAC_TABLE = build_frac_table();

  typedef struct packed {
    logic load_sample;
    logic square;
    logic accumulate;
    logic clear_window;
    logic norm_load_sum;
    logic norm_load_len;
    logic norm_step;
    logic store_log_sum;
    logic diff;
    logic scale;
    logic level;
    logic divide;
    logic emit;
    logic emit_silent;
  } slm_cmd_t;

  typedef struct packed {
    logic window_done;
    logic sum_zero;
    logic norm_done;
    logic out_busy;
  } slm_status_t;

endpackage

>>> hdl/slm_in_if.sv
interface slm_in_if
  import slm_pkg::*;
;
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] sample_word;

  modport source (output valid, output sample_word, input ready);
  modport sink (input valid, input sample_word, output ready);
endinterface

>>> hdl/slm_out_if.sv
interface slm_out_if
  import slm_pkg::*;
;
  logic                         valid;
  logic                         ready;
  logic signed [WHOLE_BITS-1:0] level_whole;
  logic [TENTH_BITS-1:0]        level_tenth;
  logic                         silent;

  modport source (output valid, output level_whole, output level_tenth, output silent,
                  input ready);
  modport sink (input valid, input level_whole, input level_tenth, input silent,
                output ready);
endinterface

>>> hdl/sound_level_db_meter.sv
// Sound level meter. Each item is a raw 32-bit I2S word whose upper 24 bits
// hold a signed sample; the block squares the sample and sums the squares over
// window_length samples (a value of zero means 65536), then gives one item
// holding the level in dB: 10log10 of the mean square plus calibration_offset
// in tenths of a dB, split into a whole part truncated toward zero and an
// absolute tenths digit, or the silent flag when the sum was zero. An ordinary
// sample passes load, square, accumulate and window check before the next
// ready. The last sample of a window with a nonzero sum then passes the
// shared normaliser, which finds the leading one of the sum and then of the
// window length at four or one bit per cycle, followed by the scaling
// multiplier, the level adder, the reciprocal divide by ten and the output
// load. The result sits in an output register, so the next sample is taken
// while it waits; a window that ends while the previous item still waits
// there is held until that item leaves.
module sound_level_db_meter
  import slm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  slm_in_if.sink                    samples,
  slm_out_if.source                 levels
);

  slm_cmd_t    cmd;
  slm_status_t status;

  slm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd)
  );

  slm_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_word (samples.sample_word),
    .out_ready   (levels.ready),
    .out_valid   (levels.valid),
    .level_whole (levels.level_whole),
    .level_tenth (levels.level_tenth),
    .silent      (levels.silent)
  );

endmodule

>>> hdl/slm_ctrl.sv
module slm_ctrl
  import slm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  slm_status_t status,
  output slm_cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE        = 4'd0;
  localparam logic [3:0] ST_SQUARE      = 4'd1;
  localparam logic [3:0] ST_ACCUM       = 4'd2;
  localparam logic [3:0] ST_CHECK       = 4'd3;
  localparam logic [3:0] ST_NORM_SUM    = 4'd4;
  localparam logic [3:0] ST_NORM_LEN    = 4'd5;
  localparam logic [3:0] ST_SCALE       = 4'd6;
  localparam logic [3:0] ST_LEVEL       = 4'd7;
  localparam logic [3:0] ST_DIVIDE      = 4'd8;
  localparam logic [3:0] ST_EMIT        = 4'd9;
  localparam logic [3:0] ST_EMIT_SILENT = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_sample = 1'b1;
          state_next      = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accumulate = 1'b1;
        state_next     = ST_CHECK;
      end
      ST_CHECK: begin
        if (!status.window_done) begin
          state_next = ST_IDLE;
        end else if (status.sum_zero) begin
          cmd.clear_window = 1'b1;
          state_next       = ST_EMIT_SILENT;
        end else begin
          cmd.clear_window  = 1'b1;
          cmd.norm_load_sum = 1'b1;
          state_next        = ST_NORM_SUM;
        end
      end
      ST_NORM_SUM: begin
        if (status.norm_done) begin
          cmd.store_log_sum = 1'b1;
          cmd.norm_load_len = 1'b1;
          state_next        = ST_NORM_LEN;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      ST_NORM_LEN: begin
        if (status.norm_done) begin
          cmd.diff   = 1'b1;
          state_next = ST_SCALE;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_LEVEL;
      end
      ST_LEVEL: begin
        cmd.level  = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.divide = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_EMIT_SILENT: begin
        if (!status.out_busy) begin
          cmd.emit_silent = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/slm_datapath.sv
module slm_datapath
  import slm_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  slm_cmd_t                      cmd,
  output slm_status_t                   status,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic signed [WORD_BITS-1:0]   sample_word,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [WHOLE_BITS-1:0]  level_whole,
  output logic [TENTH_BITS-1:0]         level_tenth,
  output logic                          silent
);

  logic [COUNT_BITS-1:0]        window_length;
  logic signed [CAL_BITS-1:0]   calibration_offset;

  logic [SAMPLE_BITS-1:0]       sample;
  logic [SQUARE_BITS-1:0]       square;
  logic [SUM_BITS-1:0]          square_sum;
  logic [COUNT_BITS-1:0]        sample_count;
  logic                         window_done;
  logic                         sum_zero;

  logic [SUM_BITS-1:0]          norm_x;
  logic [POS_BITS-1:0]          norm_p;
  logic [LOG_BITS-1:0]          log_sum;
  logic [LOG_BITS-1:0]          log_diff;
  logic                         diff_neg;
  logic [PROD_BITS-1:0]         product;
  logic [MAG_BITS-1:0]          level_mag;
  logic                         level_neg;
  logic [QUOT_BITS-1:0]         quotient;

  logic [SAMPLE_BITS-1:0]       sample_mag;
  logic [SUM_BITS:0]            sum_wide;
  logic [SUM_BITS-1:0]          sum_next;
  logic [COUNT_BITS-1:0]        count_next;
  logic [WINDOW_N_BITS-1:0]     window_n;
  logic [LOG_BITS-1:0]          log_now;
  logic [PROD_BITS:0]           product_round;
  logic [TERM_BITS-1:0]         term;
  logic signed [LEVEL_BITS-1:0] level_value;
  logic [MAG_BITS+RECIP_BITS-1:0] recip_product;
  logic [MAG_BITS-1:0]          remainder;

  assign sample_mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
  assign sum_wide   = {1'b0, square_sum} + {{(SUM_BITS-SQUARE_BITS+1){1'b0}}, square};
  assign sum_next   = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];
  assign count_next = sample_count + 1'b1;
  assign window_n   = (window_length == '0) ? (WINDOW_N_BITS'(1) << COUNT_BITS)
                                            : {1'b0, window_length};
  assign log_now    = {norm_p, LOG_FRAC_TABLE[norm_x[SUM_BITS-2 -: LOG_FRAC_BITS]]};

  assign product_round = {1'b0, product} + (PROD_BITS+1)'(64'd1 << 31);
  assign term          = TERM_BITS'(product_round >> 32);
  assign level_value   = diff_neg
    ? (LEVEL_BITS'(calibration_offset) - $signed({{(LEVEL_BITS-TERM_BITS){1'b0}}, term}))
    : (LEVEL_BITS'(calibration_offset) + $signed({{(LEVEL_BITS-TERM_BITS){1'b0}}, term}));
  assign recip_product = {{RECIP_BITS{1'b0}}, level_mag} * {{MAG_BITS{1'b0}}, RECIP_TEN};
  assign remainder     = level_mag - MAG_BITS'({quotient, 3'b000} + {quotient, 1'b0});

  assign status.window_done = window_done;
  assign status.sum_zero    = sum_zero;
  assign status.norm_done   = norm_x[SUM_BITS-1] || (norm_p == '0);
  assign status.out_busy    = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length      <= WINDOW_RESET;
      calibration_offset <= CAL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WINDOW_LENGTH:      window_length      <= cfg_data[COUNT_BITS-1:0];
        CFG_CALIBRATION_OFFSET: calibration_offset <= cfg_data[CAL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum   <= '0;
      sample_count <= '0;
    end else if (cmd.clear_window) begin
      square_sum   <= '0;
      sample_count <= '0;
    end else if (cmd.accumulate) begin
      square_sum   <= sum_next;
      sample_count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      sample <= sample_word[WORD_BITS-1 -: SAMPLE_BITS];
    end
    if (cmd.square) begin
      square <= sample_mag * sample_mag;
    end
    if (cmd.accumulate) begin
      window_done <= (count_next == window_length);
      sum_zero    <= (sum_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.norm_load_sum) begin
      norm_x <= square_sum;
      norm_p <= POS_TOP;
    end else if (cmd.norm_load_len) begin
      norm_x <= {{(SUM_BITS-WINDOW_N_BITS){1'b0}}, window_n};
      norm_p <= POS_TOP;
    end else if (cmd.norm_step) begin
      if ((norm_x[SUM_BITS-1 -: 4] == 4'd0) && (norm_p >= POS_BITS'(4))) begin
        norm_x <= norm_x << 4;
        norm_p <= norm_p - POS_BITS'(4);
      end else begin
        norm_x <= norm_x << 1;
        norm_p <= norm_p - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_log_sum) begin
      log_sum <= log_now;
    end
    if (cmd.diff) begin
      diff_neg <= (log_sum < log_now);
      log_diff <= (log_sum < log_now) ? (log_now - log_sum) : (log_sum - log_now);
    end
    if (cmd.scale) begin
      product <= {{COEF_BITS{1'b0}}, log_diff} * {{LOG_BITS{1'b0}}, LEVEL_COEF};
    end
    if (cmd.level) begin
      level_neg <= level_value[LEVEL_BITS-1];
      level_mag <= level_value[LEVEL_BITS-1] ? MAG_BITS'(-level_value)
                                             : MAG_BITS'(level_value);
    end
    if (cmd.divide) begin
      quotient <= QUOT_BITS'(recip_product >> RECIP_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_silent) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      level_whole <= level_neg ? -$signed(WHOLE_BITS'(quotient)) : $signed(WHOLE_BITS'(quotient));
      level_tenth <= TENTH_BITS'(remainder);
      silent      <= 1'b0;
    end else if (cmd.emit_silent) begin
      level_whole <= '0;
      level_tenth <= '0;
      silent      <= 1'b1;
    end
  end

endmodule

>>> tb/slm_level_monitor.sv
`timescale 1ns / 1ps
module slm_level_monitor
  import slm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  slm_in_if                         samples,
  slm_out_if                        levels,
  output int                        fails,
  output int                        pending
);

  typedef struct packed {
    logic signed [9:0] whole;
    logic [3:0]        tenth;
    logic              silent;
  } level_t;

  level_t             level_q [$];
  logic [15:0]        frac_rom [64];
  logic [15:0]        window_len;
  logic signed [11:0] cal_tenths;
  logic [63:0]        square_acc;
  logic [15:0]        sample_cnt;
  int                 err_cnt = 0;

  assign fails = err_cnt;

  // Fraction of log2(1 + k/64) in Q16, by repeated squaring of a Q30 mantissa.
  function automatic logic [15:0] frac_of(int k);
    logic [63:0] m;
    logic [15:0] r;
    m = (64'd64 + 64'(k)) << 24;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      r = {r[14:0], 1'b0};
      if (m >= 64'h8000_0000) begin
        r[0] = 1'b1;
        m = m >> 1;
      end
    end
    return r;
  endfunction

  initial begin
    for (int k = 0; k < 64; k++) frac_rom[k] = frac_of(k);
  end

  function automatic logic [21:0] log2_fixed(logic [63:0] x);
    int          p;
    logic [63:0] y;
    p = 63;
    while (p > 0 && !x[p]) p--;
    if (p >= 6) y = x >> (p - 6);
    else y = x << (6 - p);
    return {6'(p), frac_rom[y[5:0]]};
  endfunction

  function automatic void take_sample(logic [31:0] w);
    logic [23:0] s;
    logic [23:0] mag;
    logic [63:0] sq;
    logic [63:0] n;
    logic [21:0] ls;
    logic [21:0] ln;
    logic [21:0] dm;
    logic [63:0] t;
    longint      lvl;
    longint      rem;
    level_t      r;
    s = w[31:8];
    mag = s[23] ? -s : s;
    sq = 64'(mag) * 64'(mag);
    if (square_acc > ~sq) square_acc = '1;
    else square_acc = square_acc + sq;
    sample_cnt = sample_cnt + 16'd1;
    if (sample_cnt != window_len) return;
    if (square_acc == 64'd0) begin
      r = '{whole: '0, tenth: '0, silent: 1'b1};
    end else begin
      n = (window_len == 16'd0) ? 64'd65536 : 64'(window_len);
      ls = log2_fixed(square_acc);
      ln = log2_fixed(n);
      dm = (ls < ln) ? ln - ls : ls - ln;
      t = (64'(dm) * 64'd1972830 + 64'h8000_0000) >> 32;
      lvl = (ls < ln) ? -longint'(t) : longint'(t);
      lvl = lvl + longint'(cal_tenths);
      rem = lvl % 10;
      if (rem < 0) rem = -rem;
      r.whole = 10'(lvl / 10);
      r.tenth = 4'(rem);
      r.silent = 1'b0;
    end
    level_q.push_back(r);
    square_acc = '0;
    sample_cnt = '0;
  endfunction

  function automatic void check_level();
    level_t exp_lvl;
    if (level_q.size() == 0) begin
      $error("level item with none expected: whole %0d tenth %0d silent %0d",
             levels.level_whole, levels.level_tenth, levels.silent);
      err_cnt++;
      return;
    end
    exp_lvl = level_q.pop_front();
    if (levels.level_whole !== exp_lvl.whole) begin
      $error("level_whole: expected %0d, got %0d", exp_lvl.whole, levels.level_whole);
      err_cnt++;
    end
    if (levels.level_tenth !== exp_lvl.tenth) begin
      $error("level_tenth: expected %0d, got %0d", exp_lvl.tenth, levels.level_tenth);
      err_cnt++;
    end
    if (levels.silent !== exp_lvl.silent) begin
      $error("silent: expected %0d, got %0d", exp_lvl.silent, levels.silent);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      window_len = 16'd20000;
      cal_tenths = -12'sd149;
      square_acc = '0;
      sample_cnt = '0;
      level_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_WINDOW_LENGTH: window_len = cfg_data;
          CFG_CALIBRATION_OFFSET: cal_tenths = cfg_data[11:0];
        endcase
      end
      if (levels.valid && levels.ready) check_level();
      if (samples.valid && samples.ready) take_sample(samples.sample_word);
    end
    pending <= level_q.size();
  end

endmodule

>>> tb/sound_level_db_meter_tb.sv
`timescale 1ns / 1ps
module sound_level_db_meter_tb;
  import slm_pkg::*;

  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 64;
  localparam int MODE_ITEMS    = 500;
  localparam int IDLE_PCT [4]  = '{0, 52, 0, 29};
  localparam int STALL_PCT [4] = '{0, 0, 52, 29};

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
  int                        idle_pct  = 0;
  int                        stall_pct = 0;
  int                        cycles    = 0;
  int                        fails;
  int                        pending;
  logic [15:0]               win_cfg   = 16'd20000;
  logic [15:0]               win_fill  = '0;

  slm_in_if  in_ch ();
  slm_out_if out_ch ();

  sound_level_db_meter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (in_ch),
    .levels    (out_ch)
  );

  slm_level_monitor monitor (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (in_ch),
    .levels    (out_ch),
    .fails     (fails),
    .pending   (pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    if (idx == CFG_WINDOW_LENGTH) win_cfg = val;
  endtask

  task automatic send_word(input logic [31:0] w);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample_word <= w;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    win_fill = win_fill + 16'd1;
    if (win_fill == win_cfg) win_fill = '0;
  endtask

  // The block may still be busy with an item that gives no level.
  task automatic settle();
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_word(int style);
    logic [23:0] s;
    case (style)
      0: s = 24'($urandom);
      1: s = 24'($urandom_range(16)) - 24'd8;
      2: s = '0;
      default: begin
        case ($urandom_range(3))
          0: s = 24'h7FFFFF;
          1: s = 24'h800000;
          2: s = 24'hFFFFFF;
          default: s = 24'h000001;
        endcase
      end
    endcase
    return {s, 8'($urandom)};
  endfunction

  function automatic logic [15:0] pick_cal();
    case ($urandom_range(9))
      0: return 16'hF830;
      1: return 16'd2000;
      2: return {4'($urandom), 12'h800};
      3: return {4'($urandom), 12'h7FF};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_phase(output int sent);
    int sz;
    int n;
    int style;
    settle();
    case ($urandom_range(99)) inside
      [0:69]:  sz = $urandom_range(1, 16);
      [70:94]: sz = $urandom_range(17, 200);
      default: sz = $urandom_range(201, 600);
    endcase
    if (sz <= int'(win_fill)) sz = int'(win_fill) + 1;
    write_reg(CFG_WINDOW_LENGTH, 16'(sz));
    if ($urandom_range(9) < 7) write_reg(CFG_CALIBRATION_OFFSET, pick_cal());
    n = sz * ((sz > 200) ? 1 : $urandom_range(1, 3)) - int'(win_fill);
    if ($urandom_range(3) == 0) n += $urandom_range(sz - 1);
    case ($urandom_range(9)) inside
      [0:4]:   style = 0;
      [5:6]:   style = 1;
      7:       style = 2;
      default: style = 3;
    endcase
    for (int i = 0; i < n; i++) begin
      send_word(pick_word(style));
      if ($urandom_range(299) == 0) begin
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
    end
    in_ch.valid <= 1'b0;
    sent = n;
  endtask

  initial begin
    int sent;
    int total;
    in_ch.valid       = 1'b0;
    in_ch.sample_word = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_reg(CFG_WINDOW_LENGTH, 16'd1);
    write_reg(CFG_CALIBRATION_OFFSET, 16'd0);
    send_word(32'h0000_0000);
    send_word(32'h0000_00FF);
    send_word(32'h7FFF_FF00);
    send_word(32'h8000_0000);
    send_word(32'hFFFF_FF00);
    send_word(32'h0000_0100);
    send_word(32'hFFFF_FFFF);
    send_word(32'h7FFF_FFFF);
    send_word(32'h5555_5555);
    send_word(32'hAAAA_AAAA);
    settle();
    write_reg(CFG_WINDOW_LENGTH, 16'd3);
    write_reg(CFG_CALIBRATION_OFFSET, 16'hFFFB);
    send_word(32'h0000_0100);
    send_word(32'h0000_0037);
    send_word(32'h0000_00C4);
    settle();
    write_reg(CFG_WINDOW_LENGTH, 16'd2);
    write_reg(CFG_CALIBRATION_OFFSET, 16'hF7FF);
    send_word(32'h7FFF_FF00);
    send_word(32'h8000_0000);
    settle();
    write_reg(CFG_WINDOW_LENGTH, 16'd1);
    write_reg(CFG_CALIBRATION_OFFSET, 16'h0800);
    send_word(32'h0000_0100);
    settle();
    write_reg(CFG_WINDOW_LENGTH, 16'd4);
    write_reg(CFG_CALIBRATION_OFFSET, 16'hFF6B);
    repeat (4) send_word(pick_word(2));
    settle();

    for (int mode = 0; mode < 4; mode++) begin
      idle_pct  = IDLE_PCT[mode];
      stall_pct = STALL_PCT[mode];
      total = 0;
      while (total < MODE_ITEMS) begin
        run_phase(sent);
        total += sent;
      end
    end

    settle();
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
